@@ sv/lr_pkg.sv @@
// Shared opcode type for the line rasterizer.
package lr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage

@@ sv/lr_front.sv @@
// Front end: classify an item and precompute line setup for start commands.
module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  op_e                   op_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [7:0]            color_i,
  output logic [7*COORD_BITS+12:0] cmd_o
);

  localparam int EW = COORD_BITS + 2;

  typedef struct packed {
    op_e                   op;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  x_neg;
    logic                  y_neg;
    logic [EW-1:0]         err;
    logic [7:0]            color;
  } cmd_t;

  cmd_t cmd;

  always_comb begin
    cmd.op    = op_i;
    cmd.x0    = start_x_i;
    cmd.y0    = start_y_i;
    cmd.x1    = end_x_i;
    cmd.y1    = end_y_i;
    cmd.color = color_i;
    // Step toward smaller coordinates unless start is below end
    cmd.x_neg = !(start_x_i < end_x_i);
    cmd.y_neg = !(start_y_i < end_y_i);
    cmd.dx    = (end_x_i >= start_x_i) ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
    cmd.dy    = (end_y_i >= start_y_i) ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
    // Larger delta halved, negative when dy is at least dx
    if (cmd.dx > cmd.dy) begin
      cmd.err = {2'b00, cmd.dx >> 1};
    end else begin
      cmd.err = EW'(-$signed({2'b00, cmd.dy >> 1}));
    end
  end

  assign cmd_o = cmd;

endmodule

@@ sv/lr_queue.sv @@
// Small flop-based FIFO between front and back end.
module lr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == (AW+1)'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/lr_back.sv @@
// Back end: line state, Bresenham step and registered pixel output.
module lr_back
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7*COORD_BITS+12:0]  cmd_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      pixel_valid_o,
  output logic [COORD_BITS-1:0]     pixel_x_o,
  output logic [COORD_BITS-1:0]     pixel_y_o,
  output logic [7:0]                pixel_color_o,
  output logic                      last_pixel_o
);

  localparam int EW = COORD_BITS + 2;

  typedef struct packed {
    op_e                   op;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  x_neg;
    logic                  y_neg;
    logic [EW-1:0]         err;
    logic [7:0]            color;
  } cmd_t;

  cmd_t cmd;

  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                  x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic [7:0]            color_q, color_d;
  logic                  busy_q, busy_d;

  logic                  ovalid_q;
  logic                  pv_q, pv_d, last_q, last_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [7:0]            pc_q, pc_d;

  logic                  pop;
  logic signed [EW-1:0]  dx_s, dy_s;
  logic                  move_x, move_y;

  assign cmd  = cmd_t'(cmd_i);
  assign pop  = cmd_valid_i && (!ovalid_q || out_ready_i);
  assign cmd_pop_o = pop;
  assign dx_s = $signed({2'b00, dx_q});
  assign dy_s = $signed({2'b00, dy_q});
  assign move_x = (err_q > -dx_s);
  assign move_y = (err_q < dy_s);

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    x_neg_d = x_neg_q;
    y_neg_d = y_neg_q;
    err_d   = err_q;
    color_d = color_q;
    busy_d  = busy_q;
    pv_d    = 1'b0;
    last_d  = 1'b0;
    px_d    = '0;
    py_d    = '0;
    pc_d    = '0;
    unique case (cmd.op)
      OP_START: begin
        cur_x_d = cmd.x0;
        cur_y_d = cmd.y0;
        tgt_x_d = cmd.x1;
        tgt_y_d = cmd.y1;
        dx_d    = cmd.dx;
        dy_d    = cmd.dy;
        x_neg_d = cmd.x_neg;
        y_neg_d = cmd.y_neg;
        err_d   = $signed(cmd.err);
        color_d = cmd.color;
      end
      OP_STEP: begin
        if (busy_q) begin
          if (move_x) begin
            cur_x_d = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
          end
          if (move_y) begin
            cur_y_d = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
          end
          err_d = err_q - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
        end
      end
      default: ;
    endcase
    // Emit a pixel for every start and for every step of an active line
    if (cmd.op == OP_START || busy_q) begin
      pv_d   = 1'b1;
      px_d   = cur_x_d;
      py_d   = cur_y_d;
      pc_d   = color_d;
      last_d = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
      busy_d = !last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q   <= busy_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      x_neg_q <= x_neg_d;
      y_neg_q <= y_neg_d;
      err_q   <= err_d;
      color_q <= color_d;
      pv_q    <= pv_d;
      last_q  <= last_d;
      px_q    <= px_d;
      py_q    <= py_d;
      pc_q    <= pc_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign pixel_valid_o = pv_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = last_q;

endmodule

@@ sv/line_rasterizer_top.sv @@
// Top level of the Bresenham line rasterizer.
// Bresenham line rasterizer, one pixel transaction out for every transaction in.
// A start command (tuser = 0) loads both endpoints and the color and emits
// the start pixel; a step command (tuser = 1) advances the active line by one
// pixel. The pixel that lands on the endpoint carries tlast and ends the
// line. A step with no active line produces a transaction with tuser = 0 and
// all data zero. Throughput is one transaction per clock while the output
// side is ready; the error update in the back end is combinational. Data
// passes through the command queue and then the output register.
// The front end computes deltas, step directions and the initial error term
// and pushes a command into a QUEUE_DEPTH-entry queue; the back end pops it
// whenever its output register is empty or being drained, so either side may
// stall without stopping the other until the queue fills or runs empty.
module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int COORD_BITS  = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tuser: op (0 start, 1 step)
  input  logic s_axis_tuser,
  // tdata from bit 0: start_x, start_y, end_x, end_y, color, zero padding
  input  logic [((4*COORD_BITS+8+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tuser: pixel_valid
  output logic m_axis_tuser,
  // tlast: last_pixel
  output logic m_axis_tlast,
  // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero padding
  output logic [((2*COORD_BITS+8+7)/8)*8-1:0] m_axis_tdata
);

  localparam int C     = COORD_BITS;
  localparam int CMD_W = 7*C + 13;
  localparam int OUT_W = ((2*C+8+7)/8)*8;

  logic [CMD_W-1:0] front_cmd, back_cmd;
  logic             q_full, q_valid, q_pop;
  logic [C-1:0]     px, py;
  logic [7:0]       pc;
  op_e              in_op;

  // Accept while the queue has room
  assign s_axis_tready = !q_full;
  assign in_op = op_e'(s_axis_tuser);

  lr_front #(
    .COORD_BITS(C)
  ) u_front (
    .op_i      (in_op),
    .start_x_i (s_axis_tdata[C-1:0]),
    .start_y_i (s_axis_tdata[2*C-1:C]),
    .end_x_i   (s_axis_tdata[3*C-1:2*C]),
    .end_y_i   (s_axis_tdata[4*C-1:3*C]),
    .color_i   (s_axis_tdata[4*C+7:4*C]),
    .cmd_o     (front_cmd)
  );

  lr_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (back_cmd),
    .valid_o     (q_valid)
  );

  lr_back #(
    .COORD_BITS(C)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (back_cmd),
    .cmd_valid_i   (q_valid),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_valid_o (m_axis_tuser),
    .pixel_x_o     (px),
    .pixel_y_o     (py),
    .pixel_color_o (pc),
    .last_pixel_o  (m_axis_tlast)
  );

  // Pack x, y, color from the low bits up, zero-fill to whole bytes
  assign m_axis_tdata = OUT_W'({pc, py, px});

endmodule

@@ tb/sv/line_rasterizer_top_tb.sv @@
// Self-checking stream testbench for the Bresenham line rasterizer top level.
module line_rasterizer_top_tb;
  import lr_pkg::*;

  localparam int COORD_BITS   = 8;
  localparam int S_DATA_W     = ((4*COORD_BITS+8+7)/8)*8;
  localparam int M_DATA_W     = ((2*COORD_BITS+8+7)/8)*8;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT    = 4000000;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One expected pixel transaction on the output stream.
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic [7:0] color;
    logic   last;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic                s_axis_tuser;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Line state as the predictor sees it.
  coord_t            pen_x, pen_y, goal_x, goal_y, span_x, span_y;
  logic              x_back, y_back;
  logic signed [9:0] line_err;
  logic [7:0]        line_color;
  logic              line_active;

  pixel_t pixel_q[$];
  int     mismatch_cnt = 0;
  int     snd_idle_pct = 0;
  int     rcv_idle_pct = 0;
  bit     rcv_hold = 1'b0;

  line_rasterizer_top #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Work out the pixel that one accepted command produces and advance the line.
  function automatic pixel_t rasterize(op_e op, coord_t x0, coord_t y0, coord_t x1,
                                       coord_t y1, logic [7:0] col);
    pixel_t            pix;
    logic signed [9:0] err_old, dx_s, dy_s;
    pix = '0;
    if (op == OP_START) begin
      pen_x      = x0;
      pen_y      = y0;
      goal_x     = x1;
      goal_y     = y1;
      x_back     = !(x0 < x1);
      y_back     = !(y0 < y1);
      span_x     = x_back ? x0 - x1 : x1 - x0;
      span_y     = y_back ? y0 - y1 : y1 - y0;
      dx_s       = {2'b00, span_x};
      dy_s       = {2'b00, span_y};
      line_err   = (span_x > span_y) ? (dx_s >>> 1) : -(dy_s >>> 1);
      line_color = col;
    end else begin
      // A step with no line in progress yields an all-zero, invalid pixel.
      if (!line_active) return pix;
      err_old = line_err;
      dx_s    = {2'b00, span_x};
      dy_s    = {2'b00, span_y};
      if (err_old > -dx_s) begin
        line_err = line_err - dy_s;
        pen_x    = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
      end
      if (err_old < dy_s) begin
        line_err = line_err + dx_s;
        pen_y    = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
      end
    end
    pix.valid   = 1'b1;
    pix.x       = pen_x;
    pix.y       = pen_y;
    pix.color   = line_color;
    pix.last    = (pen_x == goal_x) && (pen_y == goal_y);
    line_active = !pix.last;
    return pix;
  endfunction

  // Offer one command; called and returning just after a falling edge.
  // The valid stays high on return so back-to-back commands need no second assignment.
  task automatic push_cmd(input op_e op, input coord_t x0, input coord_t y0,
                          input coord_t x1, input coord_t y1, input logic [7:0] col,
                          output pixel_t pix);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {col, y1, x1, y0, x0};
    do @(posedge clk_i); while (!s_axis_tready);
    pix = rasterize(op, x0, y0, x1, y1, col);
    pixel_q.push_back(pix);
    @(negedge clk_i);
  endtask

  // Step command with random payload; the block ignores the data on a step.
  task automatic push_step(output pixel_t pix);
    push_cmd(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), 8'($urandom), pix);
  endtask

  // Pick a coordinate near base, clamped to the grid.
  function automatic coord_t near_coord(coord_t base);
    int v;
    v = int'(base) + $urandom_range(18) - 9;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return coord_t'(v);
  endfunction

  task automatic test_directed();
    pixel_t pix;
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    // Step before any line exists, then single-pixel lines at both grid corners.
    push_step(pix);
    push_cmd(OP_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, pix);
    push_step(pix);
    push_cmd(OP_START, 8'd255, 8'd255, 8'd255, 8'd255, 8'hff, pix);
    // Shallow line going right and down the grid.
    push_cmd(OP_START, 8'd0, 8'd0, 8'd3, 8'd1, 8'h5a, pix);
    repeat (3) push_step(pix);
    // Steep line with x running backward.
    push_cmd(OP_START, 8'd255, 8'd0, 8'd254, 8'd3, 8'ha5, pix);
    repeat (3) push_step(pix);
    // Vertical line with y running backward.
    push_cmd(OP_START, 8'd10, 8'd200, 8'd10, 8'd198, 8'h3c, pix);
    repeat (2) push_step(pix);
    // Full-grid diagonals, each abandoned by the next start.
    push_cmd(OP_START, 8'd0, 8'd255, 8'd255, 8'd0, 8'hff, pix);
    repeat (2) push_step(pix);
    push_cmd(OP_START, 8'd255, 8'd0, 8'd0, 8'd255, 8'h01, pix);
    repeat (2) push_step(pix);
    // Equal deltas: error starts at minus half of dy.
    push_cmd(OP_START, 8'd7, 8'd7, 8'd9, 8'd9, 8'hc3, pix);
    repeat (2) push_step(pix);
  endtask

  // Mostly complete lines with random endpoints, plus stray steps and early restarts.
  task automatic run_random_lines(int n_items, int snd_pct, int rcv_pct);
    pixel_t pix;
    coord_t x0, y0, x1, y1;
    int     sent;
    int     stop_at;
    int     steps;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        push_step(pix);
        sent++;
      end else begin
        x0 = coord_t'($urandom);
        y0 = coord_t'($urandom);
        if ($urandom_range(24) == 0) begin
          x1 = coord_t'($urandom);
          y1 = coord_t'($urandom);
        end else begin
          x1 = near_coord(x0);
          y1 = near_coord(y0);
        end
        push_cmd(OP_START, x0, y0, x1, y1, 8'($urandom), pix);
        sent++;
        // Drop the line early now and then by starting the next one.
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(8) : -1;
        steps   = 0;
        while (!pix.last && sent < n_items && steps != stop_at) begin
          push_step(pix);
          sent++;
          steps++;
        end
        if (pix.last && $urandom_range(7) == 0 && sent < n_items) begin
          push_step(pix);
          sent++;
        end
      end
    end
  endtask

  // Hold the output side off long enough for the queue to fill and stall the input.
  task automatic test_backpressure();
    fork
      begin
        @(posedge clk_i);
        rcv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rcv_hold = 1'b0;
      end
    join_none
    run_random_lines(40, 0, 0);
  endtask

  // Output side: randomly accept, except during a hold-off.
  always @(negedge clk_i) begin
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatch_cnt++;
    end
  endfunction

  // Compare each output transaction with the oldest expected pixel.
  always @(posedge clk_i) begin : check_pixels
    pixel_t exp_pix;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual tuser=%0b tlast=%0b tdata=%h",
                 $time, m_axis_tuser, m_axis_tlast, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        exp_pix = pixel_q.pop_front();
        check_field("pixel_valid", exp_pix.valid, m_axis_tuser);
        check_field("pixel_x", exp_pix.x, m_axis_tdata[7:0]);
        check_field("pixel_y", exp_pix.y, m_axis_tdata[15:8]);
        check_field("pixel_color", exp_pix.color, m_axis_tdata[23:16]);
        check_field("last_pixel", exp_pix.last, m_axis_tlast);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    line_active   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    run_random_lines(360, 35, 78);
    run_random_lines(360, 78, 35);
    run_random_lines(360, 0, 0);
    s_axis_tvalid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("line_rasterizer_top_tb: done, clean");
    end else begin
      $display("line_rasterizer_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("line_rasterizer_top_tb: done, errors");
    $finish;
  end

endmodule
